// File: hdl/plp_pkg.sv
// ----------------------------------------------------------------------------
// Power log line parser package
// Shared constants, the field layout table and the digit decode type.
// ----------------------------------------------------------------------------
package plp_pkg;

    localparam int unsigned POS_W   = 7;
    localparam int unsigned FIELD_W = 5;
    localparam int unsigned ACC_W   = 34;

    localparam logic [FIELD_W-1:0] NUM_FIELDS = 5'd17;
    localparam logic [FIELD_W-1:0] LAST_FIELD = 5'd16;
    localparam logic [FIELD_W-1:0] SUM_FIELD  = 5'd15;
    localparam logic [POS_W-1:0]   CHECK_SPAN = 7'd74;
    localparam logic [POS_W-1:0]   POS_MAX    = 7'd127;

    // One bit per field, set where the field carries hexadecimal digits.
    localparam logic [16:0] HEX_FIELDS = 17'h1C200;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;

    typedef struct packed {
        logic       valid;
        logic       hex;
        logic [3:0] value;
    } digit_t;

    // Position of the terminating character of each field.
    function automatic logic [POS_W-1:0] field_end(input logic [FIELD_W-1:0] idx);
        logic [POS_W-1:0] pos;
        begin
            case (idx)
                5'd0:    pos = 7'd10;
                5'd1:    pos = 7'd16;
                5'd2:    pos = 7'd21;
                5'd3:    pos = 7'd27;
                5'd4:    pos = 7'd29;
                5'd5:    pos = 7'd35;
                5'd6:    pos = 7'd40;
                5'd7:    pos = 7'd46;
                5'd8:    pos = 7'd48;
                5'd9:    pos = 7'd51;
                5'd10:   pos = 7'd57;
                5'd11:   pos = 7'd62;
                5'd12:   pos = 7'd68;
                5'd13:   pos = 7'd70;
                5'd14:   pos = 7'd73;
                5'd15:   pos = 7'd76;
                5'd16:   pos = 7'd79;
                default: pos = POS_MAX;
            endcase
            return pos;
        end
    endfunction

endpackage

// File: hdl/plp_char_decode.sv
// ----------------------------------------------------------------------------
// Power log line parser character decode
// Classifies one character as a decimal or hex digit for the current field.
// ----------------------------------------------------------------------------
module plp_char_decode (
    input  logic [7:0]                  char_in,
    input  logic [plp_pkg::FIELD_W-1:0] field_num,
    output plp_pkg::digit_t             digit
);
    import plp_pkg::*;

    logic hex;

    always_comb begin
        hex = (field_num < NUM_FIELDS) ? HEX_FIELDS[field_num] : 1'b0;
        digit.hex   = hex;
        digit.valid = 1'b0;
        digit.value = 4'd0;
        if (char_in >= 8'h30 && char_in <= 8'h39) begin
            digit.valid = 1'b1;
            digit.value = 4'(char_in - 8'h30);
        end else if (hex && char_in >= 8'h61 && char_in <= 8'h66) begin
            digit.valid = 1'b1;
            digit.value = 4'(char_in - 8'h57);
        end else if (hex && char_in >= 8'h41 && char_in <= 8'h46) begin
            digit.valid = 1'b1;
            digit.value = 4'(char_in - 8'h37);
        end
    end

endmodule

// File: hdl/power_log_line_parser.sv
// ----------------------------------------------------------------------------
// Power log line parser
// Parses a fixed-layout 81-character telemetry line, CR and LF included, into 17 field values
// and checks its 8-bit sum and xor checksums.
// ----------------------------------------------------------------------------
//
//  channel   dir  beat contents
//  --------  ---  ------------------------------------------------------------
//  s_axis    in   tdata: one line character
//  m_axis    out  tdata: field value, checks and flags; tuser: field index;
//                 tlast: final field of the line
//
// One character is taken every cycle unless stalled as below. A character
// sits in the input register and its result, if any, is loaded into the
// result register as it leaves. When the result register holds a beat
// that is not taken, a character that ends a field waits in the input register
// and s_tready drops; characters that end no field still pass through.
// Reset (aresetn low, synchronous) empties both registers and clears the line
// state; an LF character does the same to the line state.
//
module power_log_line_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [33:0] field_value, [34] checksum_ok,
                                   // [35] format_ok, [43:36] sum_check,
                                   // [51:44] xor_check, [55:52] zero
    output logic [4:0]  m_tuser,   // [4:0] field_index
    output logic        m_tlast    // line_done
);
    import plp_pkg::*;

    // Input register.
    logic             in_valid_reg;
    logic [7:0]       in_data_reg;

    // Line state.
    logic [POS_W-1:0]   char_pos_reg,   char_pos_next;
    logic [ACC_W-1:0]   acc_reg,        acc_next;
    logic [FIELD_W-1:0] field_num_reg,  field_num_next;
    logic [7:0]         run_sum_reg,    run_sum_next;
    logic [7:0]         run_xor_reg,    run_xor_next;
    logic [7:0]         recv_sum_reg,   recv_sum_next;
    logic               fmt_err_reg,    fmt_err_next;

    // Result register.
    logic               out_valid_reg;
    logic [FIELD_W-1:0] out_index_reg;
    logic [ACC_W-1:0]   out_value_reg;
    logic               out_last_reg;
    logic               out_cksum_ok_reg;
    logic               out_fmt_ok_reg;
    logic [7:0]         out_sum_reg;
    logic [7:0]         out_xor_reg;

    digit_t             digit;
    logic               is_lf;
    logic               line_over;
    logic               at_end;
    logic               is_last;
    logic [7:0]         term_char;
    logic [7:0]         sum_chk;
    logic               cksum_ok;
    logic               has_result;
    logic               out_free;
    logic               proc_fire;
    logic [ACC_W-1:0]   acc_times10;
    logic [ACC_W-1:0]   acc_times16;

    plp_char_decode u_decode (
        .char_in   (in_data_reg),
        .field_num (field_num_reg),
        .digit     (digit)
    );

    always_comb begin
        is_lf     = (in_data_reg == CHAR_LF);
        line_over = (field_num_reg >= NUM_FIELDS);
        at_end    = !line_over && (char_pos_reg == field_end(field_num_reg));
        is_last   = (field_num_reg == LAST_FIELD);
        term_char = is_last ? CHAR_CR : CHAR_COMMA;

        // The checksums cover the first 74 characters of the line only.
        if (char_pos_reg < CHECK_SPAN) begin
            run_sum_next = 8'(run_sum_reg + in_data_reg);
            run_xor_next = run_xor_reg ^ in_data_reg;
        end else begin
            run_sum_next = run_sum_reg;
            run_xor_next = run_xor_reg;
        end
        sum_chk  = 8'(8'd0 - run_sum_next);
        cksum_ok = is_last && (sum_chk == recv_sum_reg)
                   && (acc_reg == {{(ACC_W-8){1'b0}}, run_xor_next});

        acc_times10 = ACC_W'({acc_reg, 3'b000} + {acc_reg, 1'b0} + {{(ACC_W-1){1'b0}}, 1'b0}
                             + ACC_W'(digit.value));
        acc_times16 = {acc_reg[ACC_W-5:0], digit.value};

        fmt_err_next   = fmt_err_reg;
        acc_next       = acc_reg;
        field_num_next = field_num_reg;
        recv_sum_next  = recv_sum_reg;
        if (line_over) begin
            // Anything but LF after the final CR is a format error.
            fmt_err_next = 1'b1;
        end else if (at_end) begin
            if (in_data_reg != term_char) begin
                fmt_err_next = 1'b1;
            end
            if (field_num_reg == SUM_FIELD) begin
                recv_sum_next = acc_reg[7:0];
            end
            acc_next       = '0;
            field_num_next = 5'(field_num_reg + 5'd1);
        end else if (!digit.valid) begin
            fmt_err_next = 1'b1;
        end else begin
            acc_next = digit.hex ? acc_times16 : acc_times10;
        end

        char_pos_next = (char_pos_reg < POS_MAX) ? 7'(char_pos_reg + 7'd1) : char_pos_reg;

        // LF restarts the line and gives no result.
        if (is_lf) begin
            char_pos_next  = '0;
            acc_next       = '0;
            field_num_next = '0;
            run_sum_next   = '0;
            run_xor_next   = '0;
            recv_sum_next  = '0;
            fmt_err_next   = 1'b0;
        end

        has_result = at_end && !is_lf;
        out_free   = !out_valid_reg || m_tready;
        proc_fire  = in_valid_reg && (!has_result || out_free);
    end

    assign s_tready = !in_valid_reg || proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            char_pos_reg  <= '0;
            acc_reg       <= '0;
            field_num_reg <= '0;
            run_sum_reg   <= '0;
            run_xor_reg   <= '0;
            recv_sum_reg  <= '0;
            fmt_err_reg   <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
                in_data_reg  <= s_tdata;
            end else if (proc_fire) begin
                in_valid_reg <= 1'b0;
            end

            if (proc_fire) begin
                char_pos_reg  <= char_pos_next;
                acc_reg       <= acc_next;
                field_num_reg <= field_num_next;
                run_sum_reg   <= run_sum_next;
                run_xor_reg   <= run_xor_next;
                recv_sum_reg  <= recv_sum_next;
                fmt_err_reg   <= fmt_err_next;
            end

            if (proc_fire && has_result) begin
                out_valid_reg    <= 1'b1;
                out_index_reg    <= field_num_reg;
                out_value_reg    <= acc_reg;
                out_last_reg     <= is_last;
                out_cksum_ok_reg <= cksum_ok;
                out_fmt_ok_reg   <= !fmt_err_next;
                out_sum_reg      <= sum_chk;
                out_xor_reg      <= run_xor_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_xor_reg, out_sum_reg, out_fmt_ok_reg,
                       out_cksum_ok_reg, out_value_reg};
    assign m_tuser  = out_index_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    a_last_is_final_field: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == LAST_FIELD)
        else $error("line end flagged on a field other than the last");

    a_cksum_only_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[34] |-> m_tlast)
        else $error("checksum match reported before the final field");

    a_field_num_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        field_num_reg <= NUM_FIELDS)
        else $error("field counter ran past the line");

    a_lf_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && is_lf |=> char_pos_reg == '0 && field_num_reg == '0 && !fmt_err_reg)
        else $error("LF did not restart the line");

    a_fmt_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        fmt_err_reg && !(proc_fire && is_lf) |=> fmt_err_reg)
        else $error("format error cleared without LF");
`endif

endmodule

// File: tb/plp_field_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power log line parser result checker
// Watches both stream channels, runs every accepted character through a line
// model, predicts a beat for each field terminator and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module plp_field_checker #(
    parameter logic [16:0][3:0] FIELD_DIGITS = '0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [55:0]       m_tdata,
    input  logic [4:0]        m_tuser,
    input  logic              m_tlast,
    output int unsigned       mismatch_count,
    output int unsigned       pending_beats
);
    import plp_pkg::*;

    typedef struct packed {
        logic [FIELD_W-1:0] idx;
        logic [ACC_W-1:0]   value;
        logic               done;
        logic               sum_ok;
        logic               fmt_ok;
        logic [7:0]         sum_chk;
        logic [7:0]         xor_chk;
        logic [3:0]         pad;
    } field_beat_t;

    field_beat_t        field_beats_q[$];
    logic [POS_W-1:0]   end_pos [17];

    logic [POS_W-1:0]   char_pos;
    logic [ACC_W-1:0]   digits_acc;
    logic [FIELD_W-1:0] field_no;
    logic [7:0]         sum_run;
    logic [7:0]         xor_run;
    logic [7:0]         sum_rcvd;
    logic               fmt_err;

    int unsigned        bad_beats = 0;
    int unsigned        pending_n = 0;

    assign mismatch_count = bad_beats;
    assign pending_beats  = pending_n;

    // Terminator positions follow from the digit counts: each field is its
    // digits plus one separator.
    initial begin : layout
        int p;
        p = 0;
        for (int i = 0; i < 17; i++) begin
            p = p + FIELD_DIGITS[i];
            end_pos[i] = p[POS_W-1:0];
            p = p + 1;
        end
    end

    function automatic logic [4:0] digit_of(input logic [7:0] c, input logic hexf);
        if (c >= "0" && c <= "9")
            return {1'b1, 4'(c - 8'h30)};
        if (hexf && c >= "a" && c <= "f")
            return {1'b1, 4'(c - 8'h57)};
        if (hexf && c >= "A" && c <= "F")
            return {1'b1, 4'(c - 8'h37)};
        return 5'b0;
    endfunction

    task automatic clear_line();
        char_pos   = '0;
        digits_acc = '0;
        field_no   = '0;
        sum_run    = '0;
        xor_run    = '0;
        sum_rcvd   = '0;
        fmt_err    = 1'b0;
    endtask

    task automatic predict_char(input logic [7:0] c);
        field_beat_t b;
        logic [4:0]  dv;
        logic        hexf;
        logic [7:0]  sum_neg;
        if (c == CHAR_LF) begin
            clear_line();
        end else begin
            if (char_pos < CHECK_SPAN) begin
                sum_run = sum_run + c;
                xor_run = xor_run ^ c;
            end
            if (field_no >= NUM_FIELDS) begin
                fmt_err = 1'b1;
            end else if (char_pos == end_pos[field_no]) begin
                if (c != ((field_no == LAST_FIELD) ? CHAR_CR : CHAR_COMMA))
                    fmt_err = 1'b1;
                if (field_no == SUM_FIELD)
                    sum_rcvd = digits_acc[7:0];
                sum_neg   = 8'd0 - sum_run;
                b.idx     = field_no;
                b.value   = digits_acc;
                b.done    = (field_no == LAST_FIELD);
                b.sum_ok  = b.done && (sum_neg == sum_rcvd) &&
                            (digits_acc == {{(ACC_W-8){1'b0}}, xor_run});
                b.fmt_ok  = !fmt_err;
                b.sum_chk = sum_neg;
                b.xor_chk = xor_run;
                b.pad     = '0;
                field_beats_q.push_back(b);
                digits_acc = '0;
                field_no   = field_no + 1'b1;
            end else begin
                hexf = HEX_FIELDS[field_no];
                dv   = digit_of(c, hexf);
                if (!dv[4])
                    fmt_err = 1'b1;
                else if (hexf)
                    digits_acc = {digits_acc[ACC_W-5:0], dv[3:0]};
                else
                    digits_acc = digits_acc * 34'd10 + 34'(dv[3:0]);
            end
            if (char_pos != POS_MAX)
                char_pos = char_pos + 1'b1;
        end
    endtask

    task automatic report(input string what, input field_beat_t want, input field_beat_t seen);
        bad_beats++;
        if (bad_beats <= 10) begin
            $display("%0t: %s", $time, what);
            $display({"  expected field %0d value %0d last %0b cks %0b fmt %0b",
                      " sum %02h xor %02h pad %h"},
                     want.idx, want.value, want.done, want.sum_ok, want.fmt_ok,
                     want.sum_chk, want.xor_chk, want.pad);
            $display({"  actual   field %0d value %0d last %0b cks %0b fmt %0b",
                      " sum %02h xor %02h pad %h"},
                     seen.idx, seen.value, seen.done, seen.sum_ok, seen.fmt_ok,
                     seen.sum_chk, seen.xor_chk, seen.pad);
        end
    endtask

    task automatic check_beat();
        field_beat_t seen;
        field_beat_t want;
        seen.idx     = m_tuser;
        seen.value   = m_tdata[33:0];
        seen.done    = m_tlast;
        seen.sum_ok  = m_tdata[34];
        seen.fmt_ok  = m_tdata[35];
        seen.sum_chk = m_tdata[43:36];
        seen.xor_chk = m_tdata[51:44];
        seen.pad     = m_tdata[55:52];
        if (field_beats_q.size() == 0) begin
            report("result beat with none outstanding", '0, seen);
        end else begin
            want = field_beats_q.pop_front();
            if (seen.idx !== want.idx || seen.value !== want.value ||
                seen.done !== want.done || seen.sum_ok !== want.sum_ok ||
                seen.fmt_ok !== want.fmt_ok || seen.sum_chk !== want.sum_chk ||
                seen.xor_chk !== want.xor_chk || seen.pad !== want.pad)
                report("result beat mismatch", want, seen);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_line();
            field_beats_q.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_beat();
            if (s_tvalid && s_tready)
                predict_char(s_tdata);
        end
        pending_n <= field_beats_q.size();
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power log line parser testbench
// Streams telemetry lines, clean and damaged, into the parser under random
// flow control on both channels, while a side checker predicts and compares
// every field beat. This module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import plp_pkg::*;

    // Digit count of each field, field 16 first. The line layout and the
    // terminator positions in the checker are both derived from this.
    localparam logic [16:0][3:0] FIELD_DIGITS = {
        4'd2, 4'd2, 4'd2, 4'd1, 4'd5, 4'd4, 4'd5, 4'd2, 4'd1,
        4'd5, 4'd4, 4'd5, 4'd1, 4'd5, 4'd4, 4'd5, 4'd10
    };

    localparam int unsigned ITEM_TARGET = 1800;
    localparam int unsigned IDLE_PCT    = 38;
    localparam int unsigned HOLD_CYCLES = 300;
    // A beat can wait out the long receiver hold-off; nothing else stalls
    // both channels for nearly as long.
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef enum int unsigned {
        DIG_RANDOM,
        DIG_MAX,
        DIG_ZERO
    } digit_style_t;

    typedef enum int unsigned {
        MUT_NONE,
        MUT_CHAR,
        MUT_TRUNC,
        MUT_TRAIL,
        MUT_TERM,
        MUT_NOLF
    } line_damage_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;

    int unsigned mismatch_count;
    int unsigned pending_beats;

    // Flow control knobs shared by the sender and the receiver. calm turns
    // off idling on both sides; hold_req asks the receiver for one long
    // hold-off.
    bit          calm     = 1'b0;
    bit          hold_req = 1'b0;

    int unsigned items_sent   = 0;
    int unsigned stall_cycles = 0;

    logic [7:0]  line_q[$];

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    power_log_line_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    plp_field_checker #(
        .FIELD_DIGITS (FIELD_DIGITS)
    ) field_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pending_beats  (pending_beats)
    );

    // ASCII for one hex or decimal digit value.
    function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
        if (v < 4'd10)
            return 8'h30 + 8'(v);
        return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    // Any byte but LF, so that damage does not quietly restart the line.
    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == CHAR_LF)
            b = CHAR_CR;
        return b;
    endfunction

    // Builds one well-formed line into line_q: fields 0 to 14 with their
    // commas, then the negated byte sum and the xor of those 74 characters as
    // two hex digits each, CR and LF. With bad_sum one checksum bit is flipped.
    task automatic build_line(input digit_style_t ds, input logic upper,
                              input logic bad_sum);
        logic [7:0] sum_acc;
        logic [7:0] xor_acc;
        logic [3:0] v;
        logic       hexf;
        line_q.delete();
        sum_acc = '0;
        xor_acc = '0;
        for (int f = 0; f < 15; f++) begin
            hexf = HEX_FIELDS[f];
            for (int k = 0; k < FIELD_DIGITS[f]; k++) begin
                case (ds)
                    DIG_MAX:  v = hexf ? 4'd15 : 4'd9;
                    DIG_ZERO: v = 4'd0;
                    default:  v = hexf ? 4'($urandom_range(15)) : 4'($urandom_range(9));
                endcase
                line_q.push_back(hex_char(v, upper));
            end
            line_q.push_back(CHAR_COMMA);
        end
        foreach (line_q[i]) begin
            sum_acc = sum_acc + line_q[i];
            xor_acc = xor_acc ^ line_q[i];
        end
        sum_acc = 8'd0 - sum_acc;
        if (bad_sum) begin
            if ($urandom_range(1))
                sum_acc = sum_acc ^ (8'h01 << $urandom_range(7));
            else
                xor_acc = xor_acc ^ (8'h01 << $urandom_range(7));
        end
        line_q.push_back(hex_char(sum_acc[7:4], upper));
        line_q.push_back(hex_char(sum_acc[3:0], upper));
        line_q.push_back(CHAR_COMMA);
        line_q.push_back(hex_char(xor_acc[7:4], upper));
        line_q.push_back(hex_char(xor_acc[3:0], upper));
        line_q.push_back(CHAR_CR);
        line_q.push_back(CHAR_LF);
    endtask

    // Damages a freshly built 81-character line in one of several ways.
    task automatic damage_line(input line_damage_t kind);
        int unsigned p;
        int unsigned n;
        case (kind)
            MUT_CHAR: begin
                // Stray characters: non-digits, hex letters in decimal
                // fields, or commas where a digit belongs.
                repeat ($urandom_range(1, 3)) begin
                    p = $urandom_range(0, 78);
                    case ($urandom_range(2))
                        0:       line_q[p] = junk_byte();
                        1:       line_q[p] = 8'h61 + 8'($urandom_range(5));
                        default: line_q[p] = CHAR_COMMA;
                    endcase
                end
            end
            MUT_TRUNC: begin
                n = $urandom_range(1, 79);
                while (line_q.size() > n)
                    void'(line_q.pop_back());
                line_q.push_back(CHAR_LF);
            end
            MUT_TRAIL: begin
                repeat ($urandom_range(1, 60))
                    line_q.insert(80, junk_byte());
            end
            MUT_TERM: begin
                do
                    p = $urandom_range(0, 79);
                while (line_q[p] != CHAR_COMMA && line_q[p] != CHAR_CR);
                line_q[p] = $urandom_range(1) ? 8'h30 + 8'($urandom_range(9)) : 8'h3B;
            end
            MUT_NOLF: begin
                // The next line then runs on past the end of this one.
                void'(line_q.pop_back());
            end
            default: ;
        endcase
    endtask

    // Offers one character and returns at the edge where it is taken. Idle
    // cycles come first, decided cycle by cycle, so a gap can fall anywhere.
    task automatic send_byte(input logic [7:0] c);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_line();
        foreach (line_q[i])
            send_byte(line_q[i]);
    endtask

    // Receiver: ready at random, steady while calm, and once a long hold-off
    // so that the parser's result register stays full and s_tready drops on
    // the next field terminator.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge aclk);
            end else begin
                m_tready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: any cycle without a beat on either channel counts toward
    // the limit.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned line_no;
        int unsigned r;
        repeat (12)
            @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. A lone LF on an empty line, then two bad bytes at
        // the line start and an LF to discard them.
        send_byte(CHAR_LF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CHAR_LF);
        // Largest digits in fields 0 to 14 with upper-case hex, then all zeros.
        build_line(DIG_MAX, 1'b1, 1'b0);
        send_line();
        build_line(DIG_ZERO, 1'b0, 1'b0);
        send_line();
        // Clean format but a wrong checksum.
        build_line(DIG_RANDOM, 1'b0, 1'b1);
        send_line();
        // Invalid digits, then a wrong terminator.
        build_line(DIG_RANDOM, 1'b1, 1'b0);
        damage_line(MUT_CHAR);
        send_line();
        build_line(DIG_RANDOM, 1'b0, 1'b0);
        damage_line(MUT_TERM);
        send_line();
        // Junk after the final CR, long enough to saturate the position.
        build_line(DIG_RANDOM, 1'b0, 1'b0);
        repeat (60)
            line_q.insert(80, junk_byte());
        send_line();
        // LF in the middle of a line.
        build_line(DIG_RANDOM, 1'b1, 1'b0);
        damage_line(MUT_TRUNC);
        send_line();

        // Random part: mostly clean lines with random digits, the rest
        // damaged lines and raw noise.
        line_no = 0;
        while (items_sent < ITEM_TARGET) begin
            calm = (line_no >= 2 && line_no < 4);
            if (line_no == 6)
                hold_req = 1'b1;
            r = $urandom_range(99);
            if (r < 65) begin
                build_line(DIG_RANDOM, 1'($urandom_range(1)), $urandom_range(99) < 15);
                send_line();
            end else if (r < 93) begin
                build_line(DIG_RANDOM, 1'($urandom_range(1)), 1'b0);
                damage_line(line_damage_t'($urandom_range(1, 5)));
                send_line();
            end else begin
                repeat ($urandom_range(20, 100))
                    send_byte(8'($urandom_range(255)));
                if ($urandom_range(1))
                    send_byte(CHAR_LF);
            end
            line_no++;
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        // Let the checker see the last character, then drain the results.
        @(posedge aclk);
        while (pending_beats != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES)
            @(posedge aclk);
        if (mismatch_count == 0 && pending_beats == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
